/* src/skc_pkg.sv */
// Shared types, constants and saturating cost helpers for the Sankoff site kernel.
// No dependencies; every other file of the kernel but skc_checker imports this package.
package skc_pkg;

  localparam int STATE_COUNT = 4;
  localparam int COST_BITS   = 16;
  localparam int SLOT_BITS   = 16;
  localparam int COL_BITS    = 64;
  localparam int SYMBOL_BITS = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int ACC_BITS    = 48;
  localparam int PROD_BITS   = COST_BITS + WEIGHT_BITS;
  localparam int CFG_COUNT   = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int IN_DATA_BITS  = 216;
  localparam int OUT_DATA_BITS = 128;

  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [STATE_COUNT-1:0][COST_BITS-1:0] cvec_t;

  localparam cost_t LANE_MAX = '1;
  localparam logic [SYMBOL_BITS-1:0] GAP_CODE = SYMBOL_BITS'(STATE_COUNT);
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  typedef enum logic [1:0] {
    KIND_LEAF     = 2'd0,
    KIND_ROOTWARD = 2'd1,
    KIND_LEAFWARD = 2'd2,
    KIND_SCORE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COST_ROW_A = 3'd0,
    REG_COST_ROW_C = 3'd1,
    REG_COST_ROW_G = 3'd2,
    REG_COST_ROW_T = 3'd3,
    REG_INFINITY   = 3'd4
  } cfg_reg_t;

  // Sideband that rides with an item down the pipeline.
  typedef struct packed {
    kind_t                   kind;
    logic [SYMBOL_BITS-1:0]  symbol;
    logic [WEIGHT_BITS-1:0]  weight;
    logic                    last;
  } side_t;

  function automatic cost_t ceiling_of(logic [15:0] inf);
    if (inf > 16'(LANE_MAX)) begin
      return LANE_MAX;
    end
    return inf[COST_BITS-1:0];
  endfunction

  function automatic cost_t sat_add(cost_t a, cost_t b, cost_t ceil);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ceil}) ? ceil : s[COST_BITS-1:0];
  endfunction

  function automatic cvec_t unpack_col(logic [COL_BITS-1:0] v);
    cvec_t r;
    for (int i = 0; i < STATE_COUNT; i++) begin
      r[i] = v[SLOT_BITS*i +: COST_BITS];
    end
    return r;
  endfunction

  function automatic logic [COL_BITS-1:0] pack_col(cvec_t v);
    logic [COL_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < STATE_COUNT; i++) begin
      r[SLOT_BITS*i +: COST_BITS] = v[i];
    end
    return r;
  endfunction

  function automatic cvec_t vec_add(cvec_t a, cvec_t b, cost_t ceil);
    cvec_t r;
    for (int i = 0; i < STATE_COUNT; i++) begin
      r[i] = sat_add(a[i], b[i], ceil);
    end
    return r;
  endfunction

endpackage

/* src/skc_lane.sv */
// One parent-state lane of the min-plus step: min over child states of cost + partial.
// Depends on skc_pkg; instantiated once per state by the top level.
module skc_lane (
  input  skc_pkg::cvec_t cost_row,
  input  skc_pkg::cvec_t t_col,
  input  skc_pkg::cvec_t q_col,
  input  skc_pkg::cost_t ceil,
  output skc_pkg::cost_t mt,
  output skc_pkg::cost_t mq
);
  import skc_pkg::*;

  always_comb begin
    cost_t bt;
    cost_t bq;
    cost_t st;
    cost_t sq;
    bt = sat_add(cost_row[0], t_col[0], ceil);
    bq = sat_add(cost_row[0], q_col[0], ceil);
    for (int c = 1; c < STATE_COUNT; c++) begin
      st = sat_add(cost_row[c], t_col[c], ceil);
      sq = sat_add(cost_row[c], q_col[c], ceil);
      if (st < bt) bt = st;
      if (sq < bq) bq = sq;
    end
    mt = bt;
    mq = bq;
  end

endmodule

/* src/skc_merge.sv */
// Merge of the lane results: picks the leaf, rootward, or leafward and score column and its minimum.
// Depends on skc_pkg.
module skc_merge (
  input  skc_pkg::kind_t                       kind,
  input  logic [skc_pkg::SYMBOL_BITS-1:0]      symbol,
  input  skc_pkg::cvec_t                       mt,
  input  skc_pkg::cvec_t                       mq,
  input  skc_pkg::cost_t                       ceil,
  output logic [skc_pkg::COL_BITS-1:0]         col,
  output skc_pkg::cost_t                       minimum,
  output logic                                 bad
);
  import skc_pkg::*;

  cvec_t vec;

  always_comb begin
    vec = '0;
    bad = 1'b0;
    case (kind)
      KIND_LEAF: begin
        for (int i = 0; i < STATE_COUNT; i++) begin
          if (symbol < GAP_CODE) begin
            vec[i] = (symbol == SYMBOL_BITS'(i)) ? '0 : ceil;
          end else if (symbol == GAP_CODE) begin
            vec[i] = '0;
          end else begin
            vec[i] = ceil;
          end
        end
        bad = (symbol > GAP_CODE);
      end
      KIND_ROOTWARD: vec = mt;
      default:       vec = vec_add(mt, mq, ceil);
    endcase
  end

  always_comb begin
    minimum = vec[0];
    for (int i = 1; i < STATE_COUNT; i++) begin
      if (vec[i] < minimum) minimum = vec[i];
    end
  end

  assign col = pack_col(vec);

endmodule

/* src/sankoff_min_plus_site_kernel.sv */
// Top level of the Sankoff min-plus site kernel: config registers, five-stage pipeline.
// Depends on skc_pkg, skc_lane and skc_merge.
//
// Each input request passes through stage registers 1 to 5 in order to the result request.
// Throughput: one site per cycle while the output is not stalled.
// Each stage holds its request until the next stage frees, so a stalled output
// leaves the upstream stages free to fill.
// Reset (rst, synchronous, high): empties the pipeline, clears cost rows and the
// score accumulator, and sets infinity_cost to 65535.
module sankoff_min_plus_site_kernel (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [skc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [skc_pkg::COL_BITS-1:0]        cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata from bit 0 up: p_left_col[63:0], p_right_col[63:0], q_col[63:0],
  // symbol[3:0], weight[15:0], 4 zero bits
  input  logic [skc_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // s_tuser: kind[1:0]
  input  logic [1:0]                          s_tuser,
  // s_tlast: last_site
  input  logic                                s_tlast,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata from bit 0 up: result_col[63:0], site_minimum[15:0], score_total[47:0]
  output logic [skc_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // m_tuser: bad_symbol
  output logic                                m_tuser,
  // m_tlast: score_done
  output logic                                m_tlast
);
  import skc_pkg::*;

  // Configuration registers.
  logic [COL_BITS-1:0] cost_rows [STATE_COUNT];
  logic [15:0]         infinity_cost;
  cost_t               ceil;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATE_COUNT; i++) cost_rows[i] <= '0;
      infinity_cost <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COST_ROW_A: cost_rows[0] <= cfg_data;
        REG_COST_ROW_C: cost_rows[1] <= cfg_data;
        REG_COST_ROW_G: if (STATE_COUNT > 2) cost_rows[2 % STATE_COUNT] <= cfg_data;
        REG_COST_ROW_T: if (STATE_COUNT > 3) cost_rows[3 % STATE_COUNT] <= cfg_data;
        REG_INFINITY:   infinity_cost <= cfg_data[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign ceil = ceiling_of(infinity_cost);

  // Stage valid flags and the backpressure chain: a stage takes a request
  // when it is empty or its content moves on in the same cycle.
  logic v1, v2, v3, v4, v5;
  logic rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (s_tready) v1 <= s_tvalid;
      if (rdy2)     v2 <= v1;
      if (rdy3)     v3 <= v2;
      if (rdy4)     v4 <= v3;
      if (rdy5)     v5 <= v4;
    end
  end

  // Stage 1: unpack the request and form T = sat(p_left + p_right).
  side_t side_in;
  side_t side1;
  cvec_t t1;
  cvec_t q1;

  assign side_in.kind   = kind_t'(s_tuser);
  assign side_in.symbol = s_tdata[195:192];
  assign side_in.weight = s_tdata[211:196];
  assign side_in.last   = s_tlast;

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      t1    <= vec_add(unpack_col(s_tdata[63:0]), unpack_col(s_tdata[127:64]), ceil);
      q1    <= unpack_col(s_tdata[191:128]);
      side1 <= side_in;
    end
  end

  // Stage 2: one min-plus lane per parent state, for both T and Q.
  cvec_t mt_next;
  cvec_t mq_next;
  cvec_t mt2;
  cvec_t mq2;
  side_t side2;

  for (genvar p = 0; p < STATE_COUNT; p++) begin : g_lane
    skc_lane u_lane (
      .cost_row (unpack_col(cost_rows[p])),
      .t_col    (t1),
      .q_col    (q1),
      .ceil     (ceil),
      .mt       (mt_next[p]),
      .mq       (mq_next[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      mt2   <= mt_next;
      mq2   <= mq_next;
      side2 <= side1;
    end
  end

  // Stage 3: merge lanes into the result column and its minimum.
  logic [COL_BITS-1:0] col_next;
  cost_t               min_next;
  logic                bad_next;
  logic [COL_BITS-1:0] col3;
  cost_t               min3;
  logic                bad3;
  side_t               side3;

  skc_merge u_merge (
    .kind    (side2.kind),
    .symbol  (side2.symbol),
    .mt      (mt2),
    .mq      (mq2),
    .ceil    (ceil),
    .col     (col_next),
    .minimum (min_next),
    .bad     (bad_next)
  );

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      col3  <= col_next;
      min3  <= min_next;
      bad3  <= bad_next;
      side3 <= side2;
    end
  end

  // Stage 4: weight the site minimum.
  logic [COL_BITS-1:0]  col4;
  cost_t                min4;
  logic                 bad4;
  side_t                side4;
  logic [PROD_BITS-1:0] prod4;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      col4  <= col3;
      min4  <= min3;
      bad4  <= bad3;
      side4 <= side3;
      prod4 <= PROD_BITS'(min3) * PROD_BITS'(side3.weight);
    end
  end

  // Stage 5: saturating accumulate and the output register.
  logic [ACC_BITS-1:0] score_accumulator;
  logic [ACC_BITS:0]   acc_sum;
  logic [ACC_BITS-1:0] total_next;
  logic                is_score;

  assign is_score   = (side4.kind == KIND_SCORE);
  assign acc_sum    = {1'b0, score_accumulator} + (ACC_BITS + 1)'(prod4);
  assign total_next = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      score_accumulator <= '0;
    end else if (rdy5 && v4 && is_score) begin
      // clear after the final site of a run, else carry the running sum
      score_accumulator <= side4.last ? '0 : total_next;
    end
  end

  logic [COL_BITS-1:0] col5;
  logic [15:0]         min5;
  logic [ACC_BITS-1:0] total5;
  logic                done5;
  logic                bad5;

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      col5   <= col4;
      min5   <= 16'(min4);
      total5 <= is_score ? total_next : '0;
      done5  <= is_score && side4.last;
      bad5   <= bad4;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {total5, min5, col5};
  assign m_tuser  = bad5;
  assign m_tlast  = done5;

endmodule

/* src/skc_checker.sv */
// Port-level checks for the Sankoff site kernel, bound onto the top level.
// Depends on sankoff_min_plus_site_kernel's port list only.
module skc_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         m_tuser,
  input logic         m_tlast
);

  // hold a stalled result request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result request dropped while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result request present after reset");

  // score_done only comes from score items, bad_symbol only from leaf items
  a_done_not_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("score_done and bad_symbol both set");

  // a bad leaf never carries a score total
  a_bad_no_score: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[127:80] == 48'd0))
    else $error("bad leaf with nonzero score_total");

  // the site minimum never exceeds lane 0 of the column
  a_min_le_lane0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[79:64] <= m_tdata[15:0]))
    else $error("site_minimum above lane 0");

endmodule

bind sankoff_min_plus_site_kernel skc_checker u_skc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
